### hdl/b64d_pkg.sv
`timescale 1ns / 1ps
package b64d_pkg;

  localparam int SEXTET_W = 6;
  localparam int BYTE_W   = 8;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = QPTR_W + 1;
  localparam int PCNT_W   = 3;

  localparam logic [PCNT_W-1:0] PEND_0 = 3'd0;
  localparam logic [PCNT_W-1:0] PEND_2 = 3'd2;
  localparam logic [PCNT_W-1:0] PEND_4 = 3'd4;
  localparam logic [PCNT_W-1:0] PEND_6 = 3'd6;

  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

  typedef struct packed {
    logic                eol;
    logic [SEXTET_W-1:0] sextet;
  } b64d_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64d_qstat_t;

endpackage

### hdl/b64d_front.sv
`timescale 1ns / 1ps
module b64d_front import b64d_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_symbol,
  input  logic        in_end_of_line,
  input  b64d_qstat_t qstat,
  output logic        push,
  output b64d_entry_t push_entry
);

  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;
  localparam logic [7:0] CH_D0   = 8'h30;
  localparam logic [7:0] CH_D9   = 8'h39;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_SL   = 8'h2F;
  localparam logic [7:0] CH_PAD  = 8'h3D;

  localparam logic [7:0] OFS_LO = 8'd26;
  localparam logic [7:0] OFS_D  = 8'd52;
  localparam logic [SEXTET_W-1:0] VAL_PLUS = 6'd62;
  localparam logic [SEXTET_W-1:0] VAL_SL   = 6'd63;

  logic [7:0]          diff;
  logic [SEXTET_W-1:0] sextet;

  always_comb begin
    diff   = 8'd0;
    sextet = '0;
    case (in_symbol) inside
      [CH_UP_A:CH_UP_Z]: begin
        diff   = in_symbol - CH_UP_A;
        sextet = diff[SEXTET_W-1:0];
      end
      [CH_LO_A:CH_LO_Z]: begin
        diff   = in_symbol - CH_LO_A + OFS_LO;
        sextet = diff[SEXTET_W-1:0];
      end
      [CH_D0:CH_D9]: begin
        diff   = in_symbol - CH_D0 + OFS_D;
        sextet = diff[SEXTET_W-1:0];
      end
      CH_PLUS: sextet = VAL_PLUS;
      CH_SL:   sextet = VAL_SL;
      CH_PAD:  sextet = '0;
      default: sextet = '0;
    endcase
  end

  assign in_ready          = ~qstat.full;
  assign push              = in_valid & in_ready;
  assign push_entry.eol    = in_end_of_line;
  assign push_entry.sextet = sextet;

endmodule

### hdl/b64d_queue.sv
`timescale 1ns / 1ps
module b64d_queue import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  b64d_entry_t push_entry,
  input  logic        pop,
  output b64d_entry_t head,
  output b64d_qstat_t qstat
);

  b64d_entry_t       slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push & ~qstat.full;
  assign do_pop      = pop & ~qstat.empty;
  assign head        = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### hdl/b64d_back.sv
`timescale 1ns / 1ps
module b64d_back import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        printable_only,
  input  b64d_entry_t head,
  input  b64d_qstat_t qstat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic        out_printable
);

  logic [SEXTET_W-1:0]   pend_r, pend_nxt;
  logic [PCNT_W-1:0]     pcnt_r, pcnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]     data_r, data_nxt;
  logic                  prt_r, prt_nxt;
  logic [2*SEXTET_W-1:0] merged;
  logic [BYTE_W-1:0]     byte_v;
  logic                  emit, pr;

  assign pop    = ~qstat.empty & (~out_valid_r | out_ready);
  assign merged = {pend_r, head.sextet};
  assign pr     = (byte_v >= PRINT_LO) && (byte_v <= PRINT_HI);

  always_comb begin
    byte_v   = merged[BYTE_W-1:0];
    emit     = 1'b1;
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    case (pcnt_r)
      PEND_2: begin
        byte_v   = merged[7:0];
        pend_nxt = '0;
        pcnt_nxt = PEND_0;
      end
      PEND_4: begin
        byte_v   = merged[9:2];
        pend_nxt = {4'd0, merged[1:0]};
        pcnt_nxt = PEND_2;
      end
      PEND_6: begin
        byte_v   = merged[11:4];
        pend_nxt = {2'd0, merged[3:0]};
        pcnt_nxt = PEND_4;
      end
      default: begin
        emit     = 1'b0;
        pend_nxt = head.sextet;
        pcnt_nxt = PEND_6;
      end
    endcase
    if (!pop) begin
      emit     = 1'b0;
      pend_nxt = pend_r;
      pcnt_nxt = pcnt_r;
    end else if (head.eol) begin
      emit     = 1'b0;
      pend_nxt = '0;
      pcnt_nxt = PEND_0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ready;
    data_nxt      = data_r;
    prt_nxt       = prt_r;
    if (emit && (!printable_only || pr)) begin
      out_valid_nxt = 1'b1;
      data_nxt      = byte_v;
      prt_nxt       = pr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      pcnt_r      <= PEND_0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prt_r  <= prt_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = data_r;
  assign out_printable = prt_r;

endmodule

### hdl/base64_stream_decoder.sv
// Accepted characters pass through the queue slots, then decoded bytes are registered in the output stage.
// Throughput: one character per cycle while the queue is not full; the 4-entry queue absorbs short output stalls.
// in_ready drops only when the queue is full.
// Reset (rst_n low, synchronous) empties the queue, clears pending bits and
// sets printable_only to 1.
`timescale 1ns / 1ps
module base64_stream_decoder import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_symbol,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_printable
);

  logic        printable_only_r, printable_only_nxt;
  logic        push, pop;
  b64d_entry_t push_entry, head;
  b64d_qstat_t qstat;

  assign printable_only_nxt = cfg_wr_en ? cfg_wr_data : printable_only_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      printable_only_r <= 1'b1;
    end else begin
      printable_only_r <= printable_only_nxt;
    end
  end

  b64d_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_symbol      (in_symbol),
    .in_end_of_line (in_end_of_line),
    .qstat          (qstat),
    .push           (push),
    .push_entry     (push_entry)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  b64d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .printable_only (printable_only_r),
    .head           (head),
    .qstat          (qstat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_byte  (out_data_byte),
    .out_printable  (out_printable)
  );

endmodule

### hdl/b64d_checker.sv
`timescale 1ns / 1ps
module b64d_checker import b64d_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_printable
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte) && $stable(out_printable))
    else $error("result transaction changed while stalled");

  a_printable_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_printable == ((out_data_byte >= PRINT_LO) && (out_data_byte <= PRINT_HI)))
    else $error("printable flag does not match data byte");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_data_byte (out_data_byte),
  .out_printable (out_printable)
);
